### hw/rtl/lrupr_pkg.sv
// shared types and constants of the lru page replacement unit
package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int CFG_W     = 4;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int NUM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [NUM_W-1:0]     num_t;

  // running result of the search, handed from cell to cell
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    rank_t hit_rank;
    logic  empty;
    idx_t  empty_idx;
    idx_t  best_idx;
    rank_t best_rank;
    page_t best_page;
  } scan_rec_t;

  // update broadcast to every cell
  typedef struct packed {
    logic  en;
    idx_t  slot;
    rank_t limit;
    logic  lim_all;
    logic  write;
    page_t page;
  } upd_t;

endpackage

### hw/rtl/lrupr_cell.sv
// one frame cell: page, valid and recency rank, plus one stage of the search chain
module lrupr_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrupr_pkg::idx_t       cell_idx,
  input  lrupr_pkg::num_t       n_active,
  input  lrupr_pkg::page_t      cmp_page,
  input  logic                  clear,
  input  lrupr_pkg::upd_t       upd,
  input  lrupr_pkg::scan_rec_t  rec_i,
  output lrupr_pkg::scan_rec_t  rec_o
);

  lrupr_pkg::page_t     page_r;
  logic                 valid_r;
  lrupr_pkg::rank_t     rank_r;
  lrupr_pkg::scan_rec_t rec_nxt;
  logic                 active;

  assign active = (lrupr_pkg::NUM_W'(cell_idx) < n_active);

  always_comb begin
    rec_nxt = rec_i;
    if (!rec_i.hit && active && valid_r && (page_r == cmp_page)) begin
      rec_nxt.hit      = 1'b1;
      rec_nxt.hit_idx  = cell_idx;
      rec_nxt.hit_rank = rank_r;
    end
    if (!rec_i.empty && active && !valid_r) begin
      rec_nxt.empty     = 1'b1;
      rec_nxt.empty_idx = cell_idx;
    end
    // first cell seeds the oldest candidate
    if (active && ((cell_idx == '0) || (rank_r > rec_i.best_rank))) begin
      rec_nxt.best_idx  = cell_idx;
      rec_nxt.best_rank = rank_r;
      rec_nxt.best_page = page_r;
    end
  end

  always_ff @(posedge clk) begin
    rec_o <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (upd.en && (upd.slot == cell_idx) && upd.write) begin
      page_r <= upd.page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else if (upd.en) begin
      if (upd.slot == cell_idx) begin
        rank_r <= '0;
        if (upd.write) begin
          valid_r <= 1'b1;
        end
      end else if (valid_r && (upd.lim_all || (rank_r < upd.limit))) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/lru_page_replacement_unit.sv
// top level of the lru page replacement unit
// Fully associative LRU frame set fed by a stream of page references. Each
// accepted reference yields one result: hit, slot, evicted page and fault
// count. Every frame lives in a cell of a chain; the search result (first hit,
// first empty frame, oldest frame) walks the chain one cell per cycle, then
// a broadcast update writes pages, valid bits and ranks. The result enters
// the output register with that update; the next reference is taken once
// the result is in the output register, so no new reference is taken while
// one is still in progress. A result that waits on out_tready stalls only
// the final update. new_run in in_tuser clears all frames and the fault count
// before that reference. The active_frames register (cfg port, values 0 and
// above FRAMES act as 1 and FRAMES) should only be written while no reference
// is in progress.
module lru_page_replacement_unit (
  input  logic        clk,
  input  logic        rst_n,
  // config write: active_frames
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] page
  input  logic        in_tuser,   // [0] new_run
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [0] hit, [3:1] slot, [4] evicted_valid,
                                  // [20:5] evicted_page, [52:21] fault_count,
                                  // [55:53] zero
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

  state_t                 state_r;
  lrupr_pkg::idx_t        cnt_r;
  lrupr_pkg::page_t       page_r;
  logic [31:0]            fault_r;
  logic [lrupr_pkg::CFG_W-1:0] active_r;
  logic                   out_tvalid_r;
  logic                   o_hit_r;
  logic [2:0]             o_slot_r;
  logic                   o_ev_r;
  logic [15:0]            o_ev_page_r;
  logic [31:0]            o_fault_r;

  logic                   in_xfer;
  logic                   clear;
  logic                   upd_go;
  lrupr_pkg::num_t        cfg_ext;
  lrupr_pkg::num_t        n_active;
  lrupr_pkg::upd_t        upd;
  lrupr_pkg::scan_rec_t   rec_init;
  lrupr_pkg::scan_rec_t   rec [lrupr_pkg::FRAMES];
  lrupr_pkg::scan_rec_t   fin;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lrupr_pkg::CFG_W'(8);
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end

  // clamp active count into 1..FRAMES
  assign cfg_ext = lrupr_pkg::NUM_W'(active_r);
  always_comb begin
    priority if (cfg_ext == '0) begin
      n_active = lrupr_pkg::NUM_W'(1);
    end else if (cfg_ext > lrupr_pkg::NUM_W'(lrupr_pkg::FRAMES)) begin
      n_active = lrupr_pkg::NUM_W'(lrupr_pkg::FRAMES);
    end else begin
      n_active = cfg_ext;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign clear     = in_xfer && in_tuser;
  assign upd_go    = (state_r == S_UPD) && (!out_tvalid_r || out_tready);

  // search record entering the first cell
  always_comb begin
    rec_init = '0;
  end

  assign fin = rec[lrupr_pkg::FRAMES-1];

  // update decision from the record leaving the last cell
  always_comb begin
    upd         = '0;
    upd.en      = upd_go;
    upd.page    = page_r;
    priority if (fin.hit) begin
      upd.slot  = fin.hit_idx;
      upd.limit = fin.hit_rank;
    end else if (fin.empty) begin
      upd.slot    = fin.empty_idx;
      upd.lim_all = 1'b1;
      upd.write   = 1'b1;
    end else begin
      upd.slot  = fin.best_idx;
      upd.limit = fin.best_rank;
      upd.write = 1'b1;
    end
  end

  // the cell chain
  for (genvar k = 0; k < lrupr_pkg::FRAMES; k++) begin : g_cell
    lrupr_pkg::scan_rec_t rec_in;
    if (k == 0) begin : g_first
      assign rec_in = rec_init;
    end else begin : g_next
      assign rec_in = rec[k-1];
    end
    lrupr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (lrupr_pkg::IDX_W'(k)),
      .n_active (n_active),
      .cmp_page (page_r),
      .clear    (clear),
      .upd      (upd),
      .rec_i    (rec_in),
      .rec_o    (rec[k])
    );
  end

  // sequencer: accept, walk the chain, update and publish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      fault_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (upd_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
            if (in_tuser) begin
              fault_r <= '0;
            end
          end
        end
        S_SCAN: begin
          if (cnt_r == lrupr_pkg::IDX_W'(lrupr_pkg::FRAMES - 1)) begin
            state_r <= S_UPD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            state_r <= S_IDLE;
            if (!fin.hit && (fault_r != '1)) begin
              fault_r <= fault_r + 32'd1;
            end
            // result fields for the output register
            o_hit_r     <= fin.hit;
            o_slot_r    <= 3'(upd.slot);
            o_ev_r      <= !fin.hit && !fin.empty;
            o_ev_page_r <= (!fin.hit && !fin.empty) ? 16'(fin.best_page) : 16'd0;
            o_fault_r   <= (!fin.hit && (fault_r != '1)) ? fault_r + 32'd1 : fault_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r <= lrupr_pkg::PAGE_BITS'(in_tdata);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, o_fault_r, o_ev_page_r, o_ev_r, o_slot_r, o_hit_r};

endmodule

### verif/tb_lru_page_replacement_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the lru page replacement unit
module tb_lru_page_replacement_unit;

  // one expected result, fields as the unit reports them
  typedef struct {
    logic             hit;
    lrupr_pkg::idx_t  slot;
    logic             evicted_valid;
    lrupr_pkg::page_t evicted_page;
    logic [31:0]      fault_count;
  } lookup_res_t;

  localparam int LATENCY      = lrupr_pkg::FRAMES + 2;
  localparam int RANDOM_ITEMS = 1800;
  localparam int PHASES       = 12;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] page
  logic        in_tuser;    // [0] new_run
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // [0] hit, [3:1] slot, [4] evicted_valid,
                            // [20:5] evicted_page, [52:21] fault_count

  // shadow copy of the frame set, updated at each input transfer
  logic [3:0]       act_frames;
  lrupr_pkg::page_t frame_page [lrupr_pkg::FRAMES];
  logic             frame_valid [lrupr_pkg::FRAMES];
  int               frame_age [lrupr_pkg::FRAMES];
  logic [31:0]      run_faults;

  lookup_res_t pending_lookups[$];

  int mismatch_count;
  int refs_sent;
  int hits_seen;
  int evictions_seen;
  int cfg_writes;
  bit steady_flow;   // no idling on either side in the closing phases
  int gap_odds;      // 1 in gap_odds references is preceded by a gap, 0 for none

  lru_page_replacement_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // frame set prediction
  // ---------------------------------------------------------------------

  // register value 0 behaves as one frame, anything above FRAMES as FRAMES
  function automatic int frames_in_use();
    if (act_frames == 0) return 1;
    if (act_frames > lrupr_pkg::FRAMES) return lrupr_pkg::FRAMES;
    return int'(act_frames);
  endfunction

  function automatic void reset_frames();
    for (int i = 0; i < lrupr_pkg::FRAMES; i++) begin
      frame_page[i]  = '0;
      frame_valid[i] = 1'b0;
      frame_age[i]   = 0;
    end
    run_faults = '0;
  endfunction

  // frame s becomes most recent; valid frames younger than limit age by one,
  // inactive frames included
  function automatic void promote_frame(int s, int limit);
    for (int i = 0; i < lrupr_pkg::FRAMES; i++)
      if (i != s && frame_valid[i] && frame_age[i] < limit) frame_age[i]++;
    frame_age[s] = 0;
  endfunction

  // the fault counter saturates at all ones; that needs 2^32 misses in a run,
  // far past any simulation, so only the ordinary count is ever exercised
  function automatic lookup_res_t lru_lookup(lrupr_pkg::page_t pg, logic nr);
    lookup_res_t r;
    int          n;
    int          s;
    int          oldest;
    logic        found;
    n = frames_in_use();
    if (nr) reset_frames();
    r.hit           = 1'b0;
    r.evicted_valid = 1'b0;
    r.evicted_page  = '0;
    found           = 1'b0;
    s               = 0;
    // only the active frames are searched, lowest index wins
    for (int i = 0; i < n; i++)
      if (!r.hit && frame_valid[i] && frame_page[i] == pg) begin
        r.hit = 1'b1;
        s     = i;
      end
    if (r.hit) begin
      promote_frame(s, frame_age[s]);
    end else begin
      for (int i = 0; i < n; i++)
        if (!found && !frame_valid[i]) begin
          found = 1'b1;
          s     = i;
        end
      if (found) begin
        frame_valid[s] = 1'b1;
        frame_page[s]  = pg;
        promote_frame(s, lrupr_pkg::FRAMES + 1);
      end else begin
        // every active frame is full: replace the oldest one
        oldest = 0;
        for (int i = 0; i < n; i++)
          if (frame_age[i] > frame_age[oldest]) oldest = i;
        s               = oldest;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[s];
        frame_page[s]   = pg;
        promote_frame(s, frame_age[s]);
      end
      if (run_faults != '1) run_faults++;
    end
    r.slot        = lrupr_pkg::idx_t'(s);
    r.fault_count = run_faults;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // result side: random back-pressure and the checker
  // ---------------------------------------------------------------------

  initial begin
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!steady_flow && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // every result transfer is matched against the oldest pending lookup
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result %h with no reference outstanding", $time, out_tdata);
      end else begin
        want = pending_lookups.pop_front();
        if (want.hit) hits_seen++;
        if (want.evicted_valid) evictions_seen++;
        if (out_tdata[0] !== want.hit || out_tdata[3:1] !== want.slot ||
            out_tdata[4] !== want.evicted_valid ||
            out_tdata[20:5] !== want.evicted_page ||
            out_tdata[52:21] !== want.fault_count || out_tdata[55:53] !== 3'b000) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected hit %b slot %0d evicted %b/%h faults %0d,",
                     $time, want.hit, want.slot, want.evicted_valid, want.evicted_page,
                     want.fault_count);
            $display("  got hit %b slot %0d evicted %b/%h faults %0d pad %b",
                     out_tdata[0], out_tdata[3:1], out_tdata[4],
                     out_tdata[20:5], out_tdata[52:21], out_tdata[55:53]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // one page reference; valid is left high so back-to-back transfers stay gapless
  task automatic send_ref(input lrupr_pkg::page_t pg, input logic nr);
    if (!steady_flow && gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pg;
    in_tuser  <= nr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_lookups.push_back(lru_lookup(pg, nr));
    refs_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain_refs();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_lookups.size() != 0);
  endtask

  // register write only with the unit idle
  task automatic write_active_frames(input logic [3:0] v);
    drain_refs();
    repeat (LATENCY) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    act_frames = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // fill all eight frames from reset, hit, replace the oldest, start a new run;
  // the page values walk every page bit through both levels
  task automatic test_fill_hit_replace();
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);   // hit, frame 0 back to most recent
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h0001, 1'b0);
    send_ref(16'h8000, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'h7FFF, 1'b0);   // last empty frame
    send_ref(16'hFFFF, 1'b0);   // hit
    send_ref(16'h4321, 1'b0);   // full: oldest frame replaced
    send_ref(16'h5555, 1'b0);   // replaced page comes back as a fault
    send_ref(16'h0000, 1'b1);   // new run: frames and fault count cleared
    drain_refs();
  endtask

  // register extremes, plus shrinking the frame count in the middle of a run
  task automatic test_active_frames_extremes();
    write_active_frames(4'd0);    // acts as one frame
    send_ref(16'h0100, 1'b1);
    send_ref(16'h0100, 1'b0);
    send_ref(16'h0200, 1'b0);     // single frame replaced
    write_active_frames(4'd15);   // acts as all frames, run carries on
    send_ref(16'h0300, 1'b0);
    send_ref(16'h0400, 1'b0);
    send_ref(16'h0500, 1'b0);
    write_active_frames(4'd1);    // upper frames kept but no longer searched
    send_ref(16'h0500, 1'b0);
    write_active_frames(4'd8);    // page now resident twice, lower frame wins
    send_ref(16'h0500, 1'b0);
    send_ref(16'h0400, 1'b0);
    drain_refs();
  endtask

  // mostly references from a small working set so hits and replacements mix,
  // with stray pages and occasional new runs; every phase a fresh setting
  task automatic test_random_traffic();
    logic [3:0]       setting;
    lrupr_pkg::page_t pool [12];
    int               pool_size;
    lrupr_pkg::page_t pg;
    logic             nr;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          setting = 4'd1;
        end
        1: begin
          setting = 4'd8;
        end
        2: begin
          setting = 4'd0;
        end
        3: begin
          setting = 4'd15;
        end
        default: begin
          setting = 4'($urandom_range(0, 15));
        end
      endcase
      write_active_frames(setting);
      steady_flow = (ph >= PHASES - 2);
      gap_odds    = (ph % 3 == 2) ? 0 : 4;
      pool_size   = $urandom_range(2, 12);
      for (int k = 0; k < pool_size; k++) pool[k] = lrupr_pkg::page_t'($urandom);
      for (int j = 0; j < RANDOM_ITEMS / PHASES; j++) begin
        if ($urandom_range(0, 9) == 0) pg = lrupr_pkg::page_t'($urandom);
        else pg = pool[$urandom_range(0, pool_size - 1)];
        // odd phases keep the previous run's frames across the new setting
        nr = (j == 0 && ph % 2 == 0) || $urandom_range(0, 59) == 0;
        send_ref(pg, nr);
      end
    end
    drain_refs();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    mismatch_count = 0;
    refs_sent      = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    cfg_writes     = 0;
    steady_flow    = 1'b0;
    gap_odds       = 4;
    act_frames     = 4'd8;
    reset_frames();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_fill_hit_replace();
    test_active_frames_extremes();
    test_random_traffic();

    drain_refs();
    repeat (LATENCY) @(negedge clk);
    $display("run covered %0d page references over %0d frame-count settings",
             refs_sent, cfg_writes);
    $display("%0d hits, %0d replacements, %0d mismatches",
             hits_seen, evictions_seen, mismatch_count);
    if (mismatch_count == 0 && pending_lookups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
